[sv/ctts_pkg.sv]
package ctts_pkg;

  localparam int TASK_SLOTS_DEF = 8;

  localparam int FUNC_W  = 2;
  localparam int SEL_W   = 3;
  localparam int TIME_W  = 16;
  localparam int RUNS_W  = 8;
  localparam int STAT_W  = 2;

  localparam logic [RUNS_W-1:0] RUNS_MAX = '1;

  // operation codes carried in func
  typedef enum logic [FUNC_W-1:0] {
    OP_TICK     = 2'd0,
    OP_CREATE   = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_DELETE   = 2'd3
  } op_t;

  // response status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_NONE_READY = 2'd2,
    ST_BAD_SLOT   = 2'd3
  } status_t;

  // request broadcast to every cell
  typedef struct packed {
    logic              go;
    op_t               op;
    logic [SEL_W-1:0]  sel;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] period;
    logic [RUNS_W-1:0] runs;
  } cmd_t;

  // priority tokens passed from cell to cell
  typedef struct packed {
    logic create_taken;
    logic disp_taken;
  } chain_t;

  // what a cell reports back for the response
  typedef struct packed {
    logic              create_hit;
    logic              disp_hit;
    logic              del_hit;
    logic [RUNS_W-1:0] runs_after;
  } hit_t;

endpackage

[sv/ctts_if.sv]
interface ctts_req_if;
  logic                          valid;
  logic                          ready;
  logic [ctts_pkg::FUNC_W-1:0]   func;
  logic [ctts_pkg::SEL_W-1:0]    slot_sel;
  logic [ctts_pkg::TIME_W-1:0]   release_delay;
  logic [ctts_pkg::TIME_W-1:0]   repeat_period;
  logic [ctts_pkg::RUNS_W-1:0]   initial_runs;

  modport source (output valid, func, slot_sel, release_delay, repeat_period, initial_runs,
                  input ready);
  modport sink   (input valid, func, slot_sel, release_delay, repeat_period, initial_runs,
                  output ready);
endinterface

interface ctts_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ctts_pkg::STAT_W-1:0]   status;
  logic [ctts_pkg::SEL_W-1:0]    slot_out;
  logic [ctts_pkg::RUNS_W-1:0]   runs_left;

  modport source (output valid, status, slot_out, runs_left, input ready);
  modport sink   (input valid, status, slot_out, runs_left, output ready);
endinterface

[sv/ctts_cell.sv]
module ctts_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  ctts_pkg::cmd_t   cmd,
  input  ctts_pkg::chain_t chain_in,
  output ctts_pkg::chain_t chain_out,
  output ctts_pkg::hit_t   hit
);

  logic                          valid;
  logic [ctts_pkg::TIME_W-1:0]   rel;
  logic [ctts_pkg::TIME_W-1:0]   per;
  logic [ctts_pkg::RUNS_W-1:0]   runs;

  logic is_free;
  logic is_ready;
  logic sel_match;

  // local conditions of this slot
  assign is_free   = !valid;
  assign is_ready  = valid && (runs != '0);
  assign sel_match = (32'(cmd.sel) == IDX);

  // priority tokens: lowest slot wins, later cells see it taken
  assign chain_out.create_taken = chain_in.create_taken || is_free;
  assign chain_out.disp_taken   = chain_in.disp_taken || is_ready;

  // hits for the current request
  always_comb begin
    hit.create_hit = (cmd.op == ctts_pkg::OP_CREATE) && is_free && !chain_in.create_taken;
    hit.disp_hit   = (cmd.op == ctts_pkg::OP_DISPATCH) && is_ready && !chain_in.disp_taken;
    hit.del_hit    = (cmd.op == ctts_pkg::OP_DELETE) && valid && sel_match;
    hit.runs_after = runs - ctts_pkg::RUNS_W'(1);
  end

  // slot state update
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rel   <= '0;
      per   <= '0;
      runs  <= '0;
    end else if (cmd.go) begin
      case (cmd.op)
        ctts_pkg::OP_TICK: begin
          if (valid) begin
            if (rel == '0) begin
              if (runs != ctts_pkg::RUNS_MAX) begin
                runs <= runs + ctts_pkg::RUNS_W'(1);
              end
              if (per != '0) begin
                rel <= per;
              end
            end else begin
              rel <= rel - ctts_pkg::TIME_W'(1);
            end
          end
        end
        ctts_pkg::OP_CREATE: begin
          if (hit.create_hit) begin
            valid <= 1'b1;
            rel   <= cmd.delay;
            per   <= cmd.period;
            runs  <= cmd.runs;
          end
        end
        ctts_pkg::OP_DISPATCH: begin
          if (hit.disp_hit) begin
            if (per == '0) begin
              valid <= 1'b0;
              rel   <= '0;
              runs  <= '0;
            end else begin
              runs <= hit.runs_after;
            end
          end
        end
        ctts_pkg::OP_DELETE: begin
          if (hit.del_hit) begin
            valid <= 1'b0;
            rel   <= '0;
            per   <= '0;
            runs  <= '0;
          end
        end
        default: begin
          valid <= valid;
        end
      endcase
    end
  end

endmodule

[sv/cooperative_task_tick_scheduler.sv]
// an accepted request's response is held in the output register from the cycle after it is accepted
// throughput: one request per cycle; a new request is taken only once the waiting response is taken
// the priority tokens ripple combinationally through the row of slot cells
// reset (rst, synchronous): all slots free with zero countdown, period and runs,
// output register empty
module cooperative_task_tick_scheduler #(
  parameter int TASK_SLOTS = ctts_pkg::TASK_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ctts_req_if.sink    req,
  ctts_rsp_if.source  rsp
);

  ctts_pkg::cmd_t   cmd;
  ctts_pkg::chain_t chain [TASK_SLOTS+1];
  ctts_pkg::hit_t   hits  [TASK_SLOTS];

  logic                        accept;
  logic                        rsp_valid;
  logic [TASK_SLOTS-1:0]       create_hits;
  logic [TASK_SLOTS-1:0]       disp_hits;
  logic [TASK_SLOTS-1:0]       del_hits;
  logic [ctts_pkg::SEL_W-1:0]  slot_any;
  logic [ctts_pkg::RUNS_W-1:0] runs_any;
  ctts_pkg::status_t           status_next;
  logic [ctts_pkg::SEL_W-1:0]  slot_next;
  logic [ctts_pkg::RUNS_W-1:0] runs_next;
  ctts_pkg::status_t           status;
  logic [ctts_pkg::SEL_W-1:0]  slot_out;
  logic [ctts_pkg::RUNS_W-1:0] runs_left;

  // request handshake; output register frees as it is taken
  assign accept    = req.valid && req.ready;
  assign req.ready = !rsp_valid || rsp.ready;

  // broadcast request to the cells
  always_comb begin
    cmd.go     = accept;
    cmd.op     = ctts_pkg::op_t'(req.func);
    cmd.sel    = req.slot_sel;
    cmd.delay  = req.release_delay;
    cmd.period = req.repeat_period;
    cmd.runs   = req.initial_runs;
  end

  assign chain[0] = '0;

  // row of slot cells
  for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
    ctts_cell #(
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .hit       (hits[g])
    );
  end

  // gather the winning cell's slot number and runs
  always_comb begin
    slot_any = '0;
    runs_any = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      create_hits[i] = hits[i].create_hit;
      disp_hits[i]   = hits[i].disp_hit;
      del_hits[i]    = hits[i].del_hit;
      if (hits[i].create_hit || hits[i].disp_hit) begin
        slot_any = slot_any | ctts_pkg::SEL_W'(i);
      end
      if (hits[i].disp_hit) begin
        runs_any = runs_any | hits[i].runs_after;
      end
    end
  end

  // response fields for the current request
  always_comb begin
    status_next = ctts_pkg::ST_OK;
    slot_next   = '0;
    runs_next   = '0;
    case (cmd.op)
      ctts_pkg::OP_TICK: begin
        status_next = ctts_pkg::ST_OK;
      end
      ctts_pkg::OP_CREATE: begin
        status_next = (|create_hits) ? ctts_pkg::ST_OK : ctts_pkg::ST_FULL;
        slot_next   = slot_any;
      end
      ctts_pkg::OP_DISPATCH: begin
        status_next = (|disp_hits) ? ctts_pkg::ST_OK : ctts_pkg::ST_NONE_READY;
        slot_next   = slot_any;
        runs_next   = runs_any;
      end
      ctts_pkg::OP_DELETE: begin
        status_next = (|del_hits) ? ctts_pkg::ST_OK : ctts_pkg::ST_BAD_SLOT;
      end
      default: begin
        status_next = ctts_pkg::ST_OK;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      slot_out  <= slot_next;
      runs_left <= runs_next;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = status;
  assign rsp.slot_out  = slot_out;
  assign rsp.runs_left = runs_left;

  // checks
  a_create_one: assert property (@(posedge clk) disable iff (rst)
    $onehot0(create_hits))
    else $error("more than one slot took a create");

  a_disp_one: assert property (@(posedge clk) disable iff (rst)
    $onehot0(disp_hits))
    else $error("more than one slot served a dispatch");

  a_del_one: assert property (@(posedge clk) disable iff (rst)
    $onehot0(del_hits))
    else $error("more than one slot matched a delete");

  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted request left no response");

  a_full_token: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == ctts_pkg::OP_CREATE && !(|create_hits)) |-> chain[TASK_SLOTS].create_taken == 1'b0)
    else $error("free slot seen but create not taken");

endmodule

[verif/tb_cooperative_task_tick_scheduler.sv]
module tb_cooperative_task_tick_scheduler;

  localparam int SLOTS = ctts_pkg::TASK_SLOTS_DEF;

  typedef struct packed {
    ctts_pkg::op_t               func;
    logic [ctts_pkg::SEL_W-1:0]  sel;
    logic [ctts_pkg::TIME_W-1:0] delay;
    logic [ctts_pkg::TIME_W-1:0] period;
    logic [ctts_pkg::RUNS_W-1:0] runs;
  } sched_req_t;

  typedef struct packed {
    ctts_pkg::status_t           status;
    logic [ctts_pkg::SEL_W-1:0]  slot;
    logic [ctts_pkg::RUNS_W-1:0] left;
  } sched_rsp_t;

  logic clk;
  logic rst;

  ctts_req_if req_bus ();
  ctts_rsp_if rsp_bus ();

  cooperative_task_tick_scheduler uut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // shadow copy of the slot table
  logic                        slot_live  [SLOTS];
  logic [ctts_pkg::TIME_W-1:0] count_down [SLOTS];
  logic [ctts_pkg::TIME_W-1:0] reload     [SLOTS];
  logic [ctts_pkg::RUNS_W-1:0] runs_due   [SLOTS];

  sched_req_t pending_reqs [$];
  sched_rsp_t expected_rsps [$];

  int  src_idle_pct;
  int  sink_stall_pct;
  bit  req_fire;
  int  mismatches;
  int  op_seen [4];
  int  status_seen [4];
  int  saturations;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop
  initial begin
    #400000;
    $display("** cooperative_task_tick_scheduler: FAILED **");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    end
  endtask

  function automatic void clear_slot(int s);
    slot_live[s]  = 1'b0;
    count_down[s] = '0;
    reload[s]     = '0;
    runs_due[s]   = '0;
  endfunction

  // apply one request to the shadow table and return the response it should get
  function automatic sched_rsp_t schedule_outcome(sched_req_t rq);
    sched_rsp_t rs;
    bit         found;
    rs.status = ctts_pkg::ST_OK;
    rs.slot   = '0;
    rs.left   = '0;
    found     = 1'b0;
    case (rq.func)
      ctts_pkg::OP_TICK: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_live[s]) begin
            if (count_down[s] == '0) begin
              if (runs_due[s] == ctts_pkg::RUNS_MAX) saturations++;
              else runs_due[s] = runs_due[s] + 1'b1;
              if (reload[s] != '0) count_down[s] = reload[s];
            end else begin
              count_down[s] = count_down[s] - 1'b1;
            end
          end
        end
      end
      ctts_pkg::OP_CREATE: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!found && !slot_live[s]) begin
            slot_live[s]  = 1'b1;
            count_down[s] = rq.delay;
            reload[s]     = rq.period;
            runs_due[s]   = rq.runs;
            rs.slot       = ctts_pkg::SEL_W'(s);
            found         = 1'b1;
          end
        end
        if (!found) rs.status = ctts_pkg::ST_FULL;
      end
      ctts_pkg::OP_DISPATCH: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!found && slot_live[s] && runs_due[s] != '0) begin
            runs_due[s] = runs_due[s] - 1'b1;
            rs.left     = runs_due[s];
            rs.slot     = ctts_pkg::SEL_W'(s);
            found       = 1'b1;
            // one-shot task leaves the table once served
            if (reload[s] == '0) clear_slot(s);
          end
        end
        if (!found) rs.status = ctts_pkg::ST_NONE_READY;
      end
      default: begin
        if (int'(rq.sel) < SLOTS && slot_live[rq.sel]) clear_slot(int'(rq.sel));
        else rs.status = ctts_pkg::ST_BAD_SLOT;
      end
    endcase
    return rs;
  endfunction

  // request acceptance: predict and queue the response
  always @(posedge clk) begin
    sched_req_t rq;
    sched_rsp_t rs;
    req_fire = 1'b0;
    if (!rst && req_bus.valid && req_bus.ready) begin
      req_fire  = 1'b1;
      rq.func   = ctts_pkg::op_t'(req_bus.func);
      rq.sel    = req_bus.slot_sel;
      rq.delay  = req_bus.release_delay;
      rq.period = req_bus.repeat_period;
      rq.runs   = req_bus.initial_runs;
      rs = schedule_outcome(rq);
      op_seen[rq.func]++;
      status_seen[rs.status]++;
      expected_rsps.push_back(rs);
    end
  end

  // response monitor
  always @(posedge clk) begin
    sched_rsp_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("response with no request outstanding, status", rsp_bus.status, 0);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_bus.status !== want.status)
          report_mismatch("status", rsp_bus.status, want.status);
        if (rsp_bus.slot_out !== want.slot)
          report_mismatch("slot_out", rsp_bus.slot_out, want.slot);
        if (rsp_bus.runs_left !== want.left)
          report_mismatch("runs_left", rsp_bus.runs_left, want.left);
      end
    end
  end

  // request driver and response back-pressure
  always @(negedge clk) begin
    sched_req_t nxt;
    if (rst) begin
      req_bus.valid <= 1'b0;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
      if (!req_bus.valid || req_fire) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = pending_reqs.pop_front();
          req_bus.valid         <= 1'b1;
          req_bus.func          <= nxt.func;
          req_bus.slot_sel      <= nxt.sel;
          req_bus.release_delay <= nxt.delay;
          req_bus.repeat_period <= nxt.period;
          req_bus.initial_runs  <= nxt.runs;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  function automatic sched_req_t make_req(ctts_pkg::op_t op, int sel, int delay, int period,
                                          int runs);
    sched_req_t rq;
    rq.func   = op;
    rq.sel    = ctts_pkg::SEL_W'(sel);
    rq.delay  = ctts_pkg::TIME_W'(delay);
    rq.period = ctts_pkg::TIME_W'(period);
    rq.runs   = ctts_pkg::RUNS_W'(runs);
    return rq;
  endfunction

  // mostly short countdowns so releases happen often
  function automatic sched_req_t shaped_req(ctts_pkg::op_t op);
    int r_delay;
    int r_period;
    int r_runs;
    int delay;
    int period;
    int runs;
    r_delay  = $urandom_range(99);
    r_period = $urandom_range(99);
    r_runs   = $urandom_range(99);
    if (r_delay < 70) delay = $urandom_range(3);
    else if (r_delay < 90) delay = $urandom_range(15);
    else delay = $urandom_range(65535);
    if (r_period < 30) period = 0;
    else if (r_period < 85) period = $urandom_range(1, 4);
    else period = $urandom_range(65535);
    if (r_runs < 40) runs = $urandom_range(2);
    else if (r_runs < 80) runs = $urandom_range(255);
    else runs = $urandom_range(250, 255);
    return make_req(op, $urandom_range(7), delay, period, runs);
  endfunction

  function automatic ctts_pkg::op_t weighted_op();
    int r;
    r = $urandom_range(99);
    if (r < 35) return ctts_pkg::OP_TICK;
    if (r < 60) return ctts_pkg::OP_CREATE;
    if (r < 85) return ctts_pkg::OP_DISPATCH;
    return ctts_pkg::OP_DELETE;
  endfunction

  // random traffic in bursts: mixed, create, tick, dispatch, delete or raw noise
  task automatic queue_random(int count);
    int n;
    int kind;
    int len;
    sched_req_t rq;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(9);
      len  = $urandom_range(2, 10);
      for (int k = 0; k < len && n < count; k++) begin
        case (kind)
          4, 5: rq = shaped_req(ctts_pkg::OP_CREATE);
          6:    rq = shaped_req(ctts_pkg::OP_TICK);
          7:    rq = shaped_req(ctts_pkg::OP_DISPATCH);
          8:    rq = shaped_req(ctts_pkg::OP_DELETE);
          9:    rq = make_req(ctts_pkg::op_t'($urandom_range(3)), $urandom_range(7),
                              $urandom_range(65535), $urandom_range(65535),
                              $urandom_range(255));
          default: rq = shaped_req(weighted_op());
        endcase
        pending_reqs.push_back(rq);
        n++;
      end
    end
  endtask

  // hold until every queued request is sent and answered
  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || req_bus.valid || expected_rsps.size() != 0)
      @(posedge clk);
  endtask

  // main sequence
  initial begin
    rst = 1'b1;
    req_bus.valid         = 1'b0;
    req_bus.func          = '0;
    req_bus.slot_sel      = '0;
    req_bus.release_delay = '0;
    req_bus.repeat_period = '0;
    req_bus.initial_runs  = '0;
    rsp_bus.ready         = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    mismatches     = 0;
    saturations    = 0;
    for (int s = 0; s < SLOTS; s++) clear_slot(s);
    for (int i = 0; i < 4; i++) begin
      op_seen[i]     = 0;
      status_seen[i] = 0;
    end

    // empty table: nothing ready, bad slots at both ends
    pending_reqs.push_back(make_req(ctts_pkg::OP_DISPATCH, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(ctts_pkg::OP_DELETE, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(ctts_pkg::OP_DELETE, 7, 0, 0, 0));
    // one-shot with zero everything, and a periodic task at the field maxima
    pending_reqs.push_back(make_req(ctts_pkg::OP_CREATE, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(ctts_pkg::OP_CREATE, 0, 65535, 65535, 255));
    pending_reqs.push_back(make_req(ctts_pkg::OP_TICK, 0, 0, 0, 0));
    // one-shot served and freed, periodic served and kept
    pending_reqs.push_back(make_req(ctts_pkg::OP_DISPATCH, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(ctts_pkg::OP_DISPATCH, 0, 0, 0, 0));
    // near-full run count pushed into saturation
    pending_reqs.push_back(make_req(ctts_pkg::OP_CREATE, 0, 1, 1, 254));
    repeat (4) pending_reqs.push_back(make_req(ctts_pkg::OP_TICK, 0, 0, 0, 0));
    // fill the table, then overflow it
    pending_reqs.push_back(make_req(ctts_pkg::OP_CREATE, 0, 2, 3, 8'h55));
    pending_reqs.push_back(make_req(ctts_pkg::OP_CREATE, 0, 16'haaaa, 16'h5555, 8'haa));
    pending_reqs.push_back(make_req(ctts_pkg::OP_CREATE, 0, 16'h5555, 16'haaaa, 1));
    pending_reqs.push_back(make_req(ctts_pkg::OP_CREATE, 0, 0, 2, 0));
    pending_reqs.push_back(make_req(ctts_pkg::OP_CREATE, 0, 3, 0, 2));
    pending_reqs.push_back(make_req(ctts_pkg::OP_CREATE, 0, 1, 1, 128));
    pending_reqs.push_back(make_req(ctts_pkg::OP_CREATE, 0, 7, 7, 7));
    // delete a live slot twice, delete another, then reuse
    pending_reqs.push_back(make_req(ctts_pkg::OP_DELETE, 7, 0, 0, 0));
    pending_reqs.push_back(make_req(ctts_pkg::OP_DELETE, 7, 0, 0, 0));
    pending_reqs.push_back(make_req(ctts_pkg::OP_DELETE, 1, 0, 0, 0));
    pending_reqs.push_back(make_req(ctts_pkg::OP_DISPATCH, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(ctts_pkg::OP_CREATE, 0, 9, 9, 9));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait_quiet();

    // random traffic under each idle/stall mix, with a full drain mid-phase
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin src_idle_pct = 57; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 57; end
        3: begin src_idle_pct = 15; sink_stall_pct = 15; end
        default: begin src_idle_pct = 0; sink_stall_pct = 0; end
      endcase
      queue_random(140);
      wait_quiet();
      queue_random(140);
      wait_quiet();
    end

    repeat (4) @(negedge clk);
    if (expected_rsps.size() != 0)
      report_mismatch("responses still outstanding", expected_rsps.size(), 0);
    $display("ran %0d ticks, %0d creates, %0d dispatches, %0d deletes across five idle mixes",
             op_seen[ctts_pkg::OP_TICK], op_seen[ctts_pkg::OP_CREATE],
             op_seen[ctts_pkg::OP_DISPATCH], op_seen[ctts_pkg::OP_DELETE]);
    $display("saw %0d table-full, %0d nothing-ready, %0d bad-slot and %0d saturated releases",
             status_seen[ctts_pkg::ST_FULL], status_seen[ctts_pkg::ST_NONE_READY],
             status_seen[ctts_pkg::ST_BAD_SLOT], saturations);
    if (mismatches == 0) begin
      $display("** cooperative_task_tick_scheduler: PASSED **");
    end else begin
      $display("** cooperative_task_tick_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
